@@ rtl/dense_layer_stack_inference_assert.svh @@
// ----------------------------------------------------------------------------
// Dense layer stack assertion macros
// Shorthand for the clocked checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef DENSE_LAYER_STACK_INFERENCE_ASSERT_SVH
`define DENSE_LAYER_STACK_INFERENCE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define DLS_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dls: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define DLS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dls: next-cycle check failed");

`endif

@@ rtl/dls_pkg.sv @@
// ----------------------------------------------------------------------------
// Dense layer stack package
// Shared widths, operation and register codes, and interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dls_pkg;

	// default sizing
	localparam int MAX_WIDTH_DEF  = 32;
	localparam int MAX_LAYERS_DEF = 4;

	// fixed point formats
	localparam int PAR_W  = 16;            // Q2.13 weight / bias
	localparam int ACT_W  = 24;            // Q10.13 activation
	localparam int ACC_W  = 48;            // wrapping accumulator
	localparam int FRAC_W = 13;
	localparam int PROD_W = PAR_W + ACT_W;

	// field and register widths
	localparam int CNT_W     = 5;          // row / column / element index
	localparam int LAY_W     = 2;          // layer select
	localparam int WID_W     = 6;          // width registers
	localparam int LC_W      = 3;          // layer count register
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 6;

	// MAC pipeline: cycles from last issue until the result is in the buffer
	localparam int DRAIN_CYC = 4;

	// operation codes
	localparam logic [1:0] OP_WEIGHT = 2'd0;
	localparam logic [1:0] OP_BIAS   = 2'd1;
	localparam logic [1:0] OP_ELEM   = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LAYER_COUNT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_L1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_L2    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_L3    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH_L4    = 3'd5;

	// one MAC issue slot
	typedef struct packed {
		logic             vld;
		logic             first;
		logic             last;
		logic [CNT_W-1:0] row;
		logic             bank;
	} mac_ctl_t;

	// finished neuron output
	typedef struct packed {
		logic                    vld;
		logic [CNT_W-1:0]        row;
		logic                    bank;
		logic signed [ACT_W-1:0] value;
	} mac_res_t;

	// activation buffer read request
	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] idx;
	} act_rd_t;

	// input element write into the ping buffer
	typedef struct packed {
		logic                    vld;
		logic [CNT_W-1:0]        idx;
		logic signed [ACT_W-1:0] value;
	} act_wr_t;

	// weight / bias read address
	typedef struct packed {
		logic [LAY_W-1:0] layer;
		logic [CNT_W-1:0] row;
		logic [CNT_W-1:0] col;
	} store_rd_t;

	// sequencer states
	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_RUN   = 6'b000010,
		S_DRAIN = 6'b000100,
		S_ORD   = 6'b001000,
		S_OLOAD = 6'b010000,
		S_OWAIT = 6'b100000
	} seq_state_t;

endpackage

@@ rtl/dls_store.sv @@
// ----------------------------------------------------------------------------
// Dense layer stack parameter store
// Weight and bias memories: one write port from the input channel, one
// registered read port driven by the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dls_store #(
	parameter int MAX_WIDTH  = dls_pkg::MAX_WIDTH_DEF,
	parameter int MAX_LAYERS = dls_pkg::MAX_LAYERS_DEF
) (
	input  logic                              clk,
	input  logic                              in_acc,
	input  logic [1:0]                        operation,
	input  logic [dls_pkg::LAY_W-1:0]         layer_sel,
	input  logic [dls_pkg::CNT_W-1:0]         row_sel,
	input  logic [dls_pkg::CNT_W-1:0]         col_sel,
	input  logic signed [dls_pkg::PAR_W-1:0]  param_value,
	input  dls_pkg::store_rd_t                rd,
	output logic signed [dls_pkg::PAR_W-1:0]  w_s1,
	output logic signed [dls_pkg::PAR_W-1:0]  b_s1
);

	localparam int NUM_LAYERS = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
	localparam int W_DEPTH    = NUM_LAYERS * MAX_WIDTH * MAX_WIDTH;
	localparam int B_DEPTH    = NUM_LAYERS * MAX_WIDTH;
	localparam int WA_W       = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
	localparam int BA_W       = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;
	localparam logic [2:0] LAY_LIM = 3'(NUM_LAYERS);
	localparam logic [8:0] WID_LIM = 9'(MAX_WIDTH);

	logic signed [dls_pkg::PAR_W-1:0] wmem [W_DEPTH];
	logic signed [dls_pkg::PAR_W-1:0] bmem [B_DEPTH];

	logic            sel_ok;
	logic            col_ok;
	logic            we_w;
	logic            we_b;
	logic [WA_W-1:0] waddr_wr;
	logic [WA_W-1:0] waddr_rd;
	logic [BA_W-1:0] baddr_wr;
	logic [BA_W-1:0] baddr_rd;

	// write guards: out-of-range selectors are dropped
	assign sel_ok = ({1'b0, layer_sel} < LAY_LIM) && ({4'b0, row_sel} < WID_LIM);
	assign col_ok = {4'b0, col_sel} < WID_LIM;
	assign we_w   = in_acc && (operation == dls_pkg::OP_WEIGHT) && sel_ok && col_ok;
	assign we_b   = in_acc && (operation == dls_pkg::OP_BIAS) && sel_ok;

	// row-major addressing: (layer * W + row) * W + col
	assign waddr_wr = (WA_W'(layer_sel) * WA_W'(MAX_WIDTH) + WA_W'(row_sel))
		* WA_W'(MAX_WIDTH) + WA_W'(col_sel);
	assign waddr_rd = (WA_W'(rd.layer) * WA_W'(MAX_WIDTH) + WA_W'(rd.row))
		* WA_W'(MAX_WIDTH) + WA_W'(rd.col);
	assign baddr_wr = BA_W'(layer_sel) * BA_W'(MAX_WIDTH) + BA_W'(row_sel);
	assign baddr_rd = BA_W'(rd.layer) * BA_W'(MAX_WIDTH) + BA_W'(rd.row);

	// weight memory
	always_ff @(posedge clk) begin
		if (we_w) begin
			wmem[waddr_wr] <= param_value;
		end
		w_s1 <= wmem[waddr_rd];
	end

	// bias memory
	always_ff @(posedge clk) begin
		if (we_b) begin
			bmem[baddr_wr] <= param_value;
		end
		b_s1 <= bmem[baddr_rd];
	end

endmodule

@@ rtl/dls_act.sv @@
// ----------------------------------------------------------------------------
// Dense layer stack activation buffers
// Ping and pong vector memories with a registered read. Ping entries carry
// valid bits so that unwritten and cleared positions read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dls_act #(
	parameter int MAX_WIDTH = dls_pkg::MAX_WIDTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dls_pkg::act_wr_t                  elem_wr,
	input  dls_pkg::mac_res_t                 res,
	input  logic                              clr,
	input  dls_pkg::act_rd_t                  rd,
	output logic signed [dls_pkg::ACT_W-1:0]  rd_data
);

	localparam int IDX_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic signed [dls_pkg::ACT_W-1:0] ping_mem [MAX_WIDTH];
	logic signed [dls_pkg::ACT_W-1:0] pong_mem [MAX_WIDTH];
	logic [MAX_WIDTH-1:0]             ping_vld_q;

	logic                             wr_ping;
	logic                             wr_pong;
	logic [IDX_W-1:0]                 wr_idx;
	logic signed [dls_pkg::ACT_W-1:0] wr_val;
	logic [IDX_W-1:0]                 rd_idx;

	logic signed [dls_pkg::ACT_W-1:0] ping_s1;
	logic signed [dls_pkg::ACT_W-1:0] pong_s1;
	logic                             pvld_s1;
	logic                             bank_s1;

	// write select: layer results, else loaded input elements (never both)
	always_comb begin
		if (res.vld) begin
			wr_ping = !res.bank;
			wr_pong = res.bank;
			wr_idx  = IDX_W'(res.row);
			wr_val  = res.value;
		end else begin
			wr_ping = elem_wr.vld;
			wr_pong = 1'b0;
			wr_idx  = IDX_W'(elem_wr.idx);
			wr_val  = elem_wr.value;
		end
	end

	assign rd_idx = IDX_W'(rd.idx);

	// ping valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ping_vld_q <= '0;
		end else if (clr) begin
			ping_vld_q <= '0;
		end else if (wr_ping) begin
			ping_vld_q[wr_idx] <= 1'b1;
		end
	end

	// buffer memories
	always_ff @(posedge clk) begin
		if (wr_ping) begin
			ping_mem[wr_idx] <= wr_val;
		end
		if (wr_pong) begin
			pong_mem[wr_idx] <= wr_val;
		end
		ping_s1 <= ping_mem[rd_idx];
		pong_s1 <= pong_mem[rd_idx];
		pvld_s1 <= ping_vld_q[rd_idx];
		bank_s1 <= rd.bank;
	end

	assign rd_data = bank_s1 ? pong_s1 : (pvld_s1 ? ping_s1 : '0);

endmodule

@@ rtl/dls_mac.sv @@
// ----------------------------------------------------------------------------
// Dense layer stack MAC unit
// Shared multiply-accumulate: product register, 48-bit wrapping
// accumulator seeded with the bias, then round-half-up and saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dls_mac (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dls_pkg::mac_ctl_t                 ctl,
	input  logic signed [dls_pkg::PAR_W-1:0]  w_s1,
	input  logic signed [dls_pkg::PAR_W-1:0]  b_s1,
	input  logic signed [dls_pkg::ACT_W-1:0]  a_s1,
	output dls_pkg::mac_res_t                 res
);

	localparam int ACC_W  = dls_pkg::ACC_W;
	localparam int ACT_W  = dls_pkg::ACT_W;
	localparam int PAR_W  = dls_pkg::PAR_W;
	localparam int PROD_W = dls_pkg::PROD_W;
	localparam int FRAC_W = dls_pkg::FRAC_W;
	localparam int CNT_W  = dls_pkg::CNT_W;
	localparam int Q_W    = ACC_W + 1 - FRAC_W;

	dls_pkg::mac_ctl_t ctl_s1;
	dls_pkg::mac_ctl_t ctl_s2;
	dls_pkg::mac_ctl_t ctl_s3;

	logic signed [PROD_W-1:0] prod_s2;
	logic signed [PAR_W-1:0]  bias_s2;
	logic [ACC_W-1:0]         acc_q;
	logic [ACC_W-1:0]         prod_ext;
	logic [ACC_W-1:0]         bias_ext;
	logic [ACC_W:0]           rnd;
	logic [Q_W-1:0]           q;
	logic [Q_W-ACT_W:0]       q_hi;
	logic signed [ACT_W-1:0]  sat_val;

	logic                     res_vld_q;
	logic [CNT_W-1:0]         res_row_q;
	logic                     res_bank_q;
	logic signed [ACT_W-1:0]  res_value_q;

	// control pipeline; stage three only flags the last column of a row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1    <= '0;
			ctl_s2    <= '0;
			ctl_s3    <= '0;
			res_vld_q <= 1'b0;
		end else begin
			ctl_s1    <= ctl;
			ctl_s2    <= ctl_s1;
			ctl_s3    <= '{vld: ctl_s2.vld && ctl_s2.last, first: ctl_s2.first,
				last: ctl_s2.last, row: ctl_s2.row, bank: ctl_s2.bank};
			res_vld_q <= ctl_s3.vld;
		end
	end

	// product stage
	always_ff @(posedge clk) begin
		prod_s2 <= w_s1 * a_s1;
		bias_s2 <= b_s1;
	end

	assign prod_ext = {{(ACC_W-PROD_W){prod_s2[PROD_W-1]}}, prod_s2};
	assign bias_ext = {{(ACC_W-PAR_W-FRAC_W){bias_s2[PAR_W-1]}}, bias_s2, {FRAC_W{1'b0}}};

	// accumulate, bias enters with the first product of a row
	always_ff @(posedge clk) begin
		if (ctl_s2.vld) begin
			acc_q <= ctl_s2.first ? (bias_ext + prod_ext) : (acc_q + prod_ext);
		end
	end

	// round half up to 13 fraction bits, then clamp to 24 bits
	always_comb begin
		rnd  = {acc_q[ACC_W-1], acc_q} + (ACC_W+1)'(1 << (FRAC_W - 1));
		q    = rnd[ACC_W:FRAC_W];
		q_hi = q[Q_W-1:ACT_W-1];
		if ((&q_hi) || !(|q_hi)) begin
			sat_val = q[ACT_W-1:0];
		end else if (q[Q_W-1]) begin
			sat_val = {1'b1, {(ACT_W-1){1'b0}}};
		end else begin
			sat_val = {1'b0, {(ACT_W-1){1'b1}}};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		res_row_q   <= ctl_s3.row;
		res_bank_q  <= ctl_s3.bank;
		res_value_q <= sat_val;
	end

	assign res = '{vld: res_vld_q, row: res_row_q, bank: res_bank_q, value: res_value_q};

endmodule

@@ rtl/dls_seq.sv @@
// ----------------------------------------------------------------------------
// Dense layer stack sequencer
// Configuration registers, input handshake, row/column/layer counters that
// drive the MAC, pipeline drain between layers, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dls_seq #(
	parameter int MAX_WIDTH  = dls_pkg::MAX_WIDTH_DEF,
	parameter int MAX_LAYERS = dls_pkg::MAX_LAYERS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dls_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dls_pkg::CFG_DAT_W-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic [dls_pkg::CNT_W-1:0]             col_sel,
	input  logic signed [dls_pkg::ACT_W-1:0]      sample_value,
	input  logic                                  vector_last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [dls_pkg::CNT_W-1:0]             out_index,
	output logic signed [dls_pkg::ACT_W-1:0]      out_value,
	output logic                                  out_last,
	output dls_pkg::mac_ctl_t                     ctl,
	output dls_pkg::store_rd_t                    st_rd,
	output dls_pkg::act_rd_t                      act_rd,
	output dls_pkg::act_wr_t                      elem_wr,
	output logic                                  ping_clr,
	input  logic signed [dls_pkg::ACT_W-1:0]      act_data
);

	localparam int NUM_LAYERS = (MAX_LAYERS < 4) ? MAX_LAYERS : 4;
	localparam int VEC_LIMIT  = (MAX_WIDTH < 32) ? MAX_WIDTH : 32;
	localparam int DC_W       = (dls_pkg::DRAIN_CYC > 1) ? $clog2(dls_pkg::DRAIN_CYC) : 1;
	localparam logic [dls_pkg::LC_W-1:0]  LC_MAX  = dls_pkg::LC_W'(NUM_LAYERS);
	localparam logic [dls_pkg::WID_W-1:0] WID_MAX = dls_pkg::WID_W'(VEC_LIMIT);
	localparam logic [DC_W-1:0]           DC_END  = DC_W'(dls_pkg::DRAIN_CYC - 1);

	dls_pkg::seq_state_t state_q;

	logic [dls_pkg::LC_W-1:0]  lc_q;
	logic [dls_pkg::WID_W-1:0] wid_q [5];
	logic [dls_pkg::LAY_W-1:0] l_q;
	logic [dls_pkg::CNT_W-1:0] r_q;
	logic [dls_pkg::CNT_W-1:0] c_q;
	logic [dls_pkg::CNT_W-1:0] i_q;
	logic [DC_W-1:0]           dcnt_q;

	logic                      in_acc;
	logic [dls_pkg::LC_W-1:0]  lc_new;
	logic [dls_pkg::WID_W-1:0] wid_new;
	logic [dls_pkg::WID_W-1:0] n_in;
	logic [dls_pkg::WID_W-1:0] n_out;
	logic [dls_pkg::WID_W-1:0] n_fin;
	logic                      c_last;
	logic                      r_last;
	logic                      l_last;
	logic                      i_last;

	assign in_ready = (state_q == dls_pkg::S_IDLE);
	assign in_acc   = in_valid && in_ready;

	// register values clamp into their legal range
	always_comb begin
		lc_new = cfg_data[dls_pkg::LC_W-1:0];
		if (lc_new == '0) begin
			lc_new = dls_pkg::LC_W'(1);
		end else if (lc_new > LC_MAX) begin
			lc_new = LC_MAX;
		end
		wid_new = cfg_data[dls_pkg::WID_W-1:0];
		if (wid_new == '0) begin
			wid_new = dls_pkg::WID_W'(1);
		end else if (wid_new > WID_MAX) begin
			wid_new = WID_MAX;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lc_q     <= dls_pkg::LC_W'(1);
			wid_q[0] <= WID_MAX;
			wid_q[1] <= dls_pkg::WID_W'(1);
			wid_q[2] <= dls_pkg::WID_W'(1);
			wid_q[3] <= dls_pkg::WID_W'(1);
			wid_q[4] <= dls_pkg::WID_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				dls_pkg::REG_LAYER_COUNT: begin
					lc_q <= lc_new;
				end
				dls_pkg::REG_WIDTH_IN, dls_pkg::REG_WIDTH_L1, dls_pkg::REG_WIDTH_L2,
				dls_pkg::REG_WIDTH_L3, dls_pkg::REG_WIDTH_L4: begin
					wid_q[cfg_index - dls_pkg::CFG_IDX_W'(1)] <= wid_new;
				end
				default: begin
				end
			endcase
		end
	end

	// loop bounds of the current layer
	assign n_in   = wid_q[3'(l_q)];
	assign n_out  = wid_q[3'(l_q) + 3'd1];
	assign n_fin  = wid_q[lc_q];
	assign c_last = {1'b0, c_q} == (n_in - dls_pkg::WID_W'(1));
	assign r_last = {1'b0, r_q} == (n_out - dls_pkg::WID_W'(1));
	assign l_last = {1'b0, l_q} == (lc_q - dls_pkg::LC_W'(1));
	assign i_last = {1'b0, i_q} == (n_fin - dls_pkg::WID_W'(1));

	// input element into the ping buffer; positions past width_in are dropped
	assign elem_wr.vld   = in_acc && (operation == dls_pkg::OP_ELEM)
		&& ({1'b0, col_sel} < wid_q[0]);
	assign elem_wr.idx   = col_sel;
	assign elem_wr.value = sample_value;

	// MAC issue: source bank alternates per layer, results go to the other
	assign ctl.vld   = (state_q == dls_pkg::S_RUN);
	assign ctl.first = (c_q == '0);
	assign ctl.last  = c_last;
	assign ctl.row   = r_q;
	assign ctl.bank  = !l_q[0];

	assign st_rd.layer = l_q;
	assign st_rd.row   = r_q;
	assign st_rd.col   = c_q;

	always_comb begin
		if (state_q == dls_pkg::S_RUN) begin
			act_rd.bank = l_q[0];
			act_rd.idx  = c_q;
		end else begin
			act_rd.bank = lc_q[0];
			act_rd.idx  = i_q;
		end
	end

	assign ping_clr = (state_q == dls_pkg::S_OWAIT) && out_ready && out_last;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dls_pkg::S_IDLE;
			l_q       <= '0;
			r_q       <= '0;
			c_q       <= '0;
			i_q       <= '0;
			dcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			unique case (state_q)
				dls_pkg::S_IDLE: begin
					if (in_acc && (operation == dls_pkg::OP_ELEM) && vector_last) begin
						l_q     <= '0;
						r_q     <= '0;
						c_q     <= '0;
						state_q <= dls_pkg::S_RUN;
					end
				end
				dls_pkg::S_RUN: begin
					if (c_last) begin
						c_q <= '0;
						if (r_last) begin
							r_q     <= '0;
							dcnt_q  <= '0;
							state_q <= dls_pkg::S_DRAIN;
						end else begin
							r_q <= r_q + dls_pkg::CNT_W'(1);
						end
					end else begin
						c_q <= c_q + dls_pkg::CNT_W'(1);
					end
				end
				// let the last row reach the buffer before it is read
				dls_pkg::S_DRAIN: begin
					if (dcnt_q == DC_END) begin
						if (l_last) begin
							i_q     <= '0;
							state_q <= dls_pkg::S_ORD;
						end else begin
							l_q     <= l_q + dls_pkg::LAY_W'(1);
							state_q <= dls_pkg::S_RUN;
						end
					end else begin
						dcnt_q <= dcnt_q + DC_W'(1);
					end
				end
				dls_pkg::S_ORD: begin
					state_q <= dls_pkg::S_OLOAD;
				end
				dls_pkg::S_OLOAD: begin
					out_valid <= 1'b1;
					state_q   <= dls_pkg::S_OWAIT;
				end
				dls_pkg::S_OWAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						if (out_last) begin
							state_q <= dls_pkg::S_IDLE;
						end else begin
							i_q     <= i_q + dls_pkg::CNT_W'(1);
							state_q <= dls_pkg::S_ORD;
						end
					end
				end
				default: begin
					state_q <= dls_pkg::S_IDLE;
				end
			endcase
		end
	end

	// output beat payload
	always_ff @(posedge clk) begin
		if (state_q == dls_pkg::S_OLOAD) begin
			out_index <= i_q;
			out_value <= act_data;
			out_last  <= i_last;
		end
	end

endmodule

@@ rtl/dense_layer_stack_inference.sv @@
// ----------------------------------------------------------------------------
// Dense layer stack inference
// Fixed-point forward pass through up to four fully connected layers.
//
// Input channel (in_valid/in_ready): each beat writes a weight, writes a
// bias, or loads one input element. An element beat with vector_last set
// starts the forward pass; in_ready stays low until the last result beat
// has been taken.
// Output channel (out_valid/out_ready): one beat per element of the final
// vector, out_last on the final one. A stalled receiver simply holds the
// block in its output phase; nothing is dropped.
// From the starting beat, each layer issues every weight in turn to the
// single MAC and then drains the MAC pipeline; each output beat passes a
// read, a load and a wait state. The one MAC and the single-port
// activation read set the pace. Configuration (cfg_we/cfg_index/cfg_data)
// must be written only while idle; the block itself does not enforce it.
// Reset clears the configuration to one layer, width_in at its maximum and
// all other widths 1, and empties the input vector; stores keep no reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "dense_layer_stack_inference_assert.svh"

module dense_layer_stack_inference #(
	parameter int MAX_WIDTH  = dls_pkg::MAX_WIDTH_DEF,
	parameter int MAX_LAYERS = dls_pkg::MAX_LAYERS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [dls_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [dls_pkg::CFG_DAT_W-1:0]         cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic [dls_pkg::LAY_W-1:0]             layer_sel,
	input  logic [dls_pkg::CNT_W-1:0]             row_sel,
	input  logic [dls_pkg::CNT_W-1:0]             col_sel,
	input  logic signed [dls_pkg::PAR_W-1:0]      param_value,
	input  logic signed [dls_pkg::ACT_W-1:0]      sample_value,
	input  logic                                  vector_last,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [dls_pkg::CNT_W-1:0]             out_index,
	output logic signed [dls_pkg::ACT_W-1:0]      out_value,
	output logic                                  out_last
);

	dls_pkg::mac_ctl_t  ctl;
	dls_pkg::mac_res_t  res;
	dls_pkg::store_rd_t st_rd;
	dls_pkg::act_rd_t   act_rd;
	dls_pkg::act_wr_t   elem_wr;

	logic                             in_acc;
	logic                             ping_clr;
	logic signed [dls_pkg::PAR_W-1:0] w_s1;
	logic signed [dls_pkg::PAR_W-1:0] b_s1;
	logic signed [dls_pkg::ACT_W-1:0] act_data;

	assign in_acc = in_valid && in_ready;

	// control and output register
	dls_seq #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_LAYERS (MAX_LAYERS)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.col_sel      (col_sel),
		.sample_value (sample_value),
		.vector_last  (vector_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_index    (out_index),
		.out_value    (out_value),
		.out_last     (out_last),
		.ctl          (ctl),
		.st_rd        (st_rd),
		.act_rd       (act_rd),
		.elem_wr      (elem_wr),
		.ping_clr     (ping_clr),
		.act_data     (act_data)
	);

	// weights and biases
	dls_store #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_LAYERS (MAX_LAYERS)
	) u_store (
		.clk         (clk),
		.in_acc      (in_acc),
		.operation   (operation),
		.layer_sel   (layer_sel),
		.row_sel     (row_sel),
		.col_sel     (col_sel),
		.param_value (param_value),
		.rd          (st_rd),
		.w_s1        (w_s1),
		.b_s1        (b_s1)
	);

	// activation ping/pong buffers
	dls_act #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_act (
		.clk     (clk),
		.arst_n  (arst_n),
		.elem_wr (elem_wr),
		.res     (res),
		.clr     (ping_clr),
		.rd      (act_rd),
		.rd_data (act_data)
	);

	// shared multiply-accumulate
	dls_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.w_s1   (w_s1),
		.b_s1   (b_s1),
		.a_s1   (act_data),
		.res    (res)
	);

	// checks
	`DLS_ASSERT_SAME(a_out_busy, out_valid, !in_ready)
	`DLS_ASSERT_SAME(a_res_busy, res.vld, !in_ready)
	`DLS_ASSERT_NEXT(a_start_busy, in_acc && (operation == dls_pkg::OP_ELEM) && vector_last, !in_ready)
	`DLS_ASSERT_NEXT(a_done_idle, out_valid && out_ready && out_last, in_ready && !out_valid)

endmodule
